[hdl/clau_pkg.sv]
package clau_pkg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_WRITE,
        S_FREE,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        OP_ALLOC   = 2'd0,
        OP_RELEASE = 2'd1,
        OP_CLEAR   = 2'd2,
        OP_NONE    = 2'd3
    } t_op;

    localparam logic [1:0] FIT_FIRST = 2'd0;
    localparam logic [1:0] FIT_BEST  = 2'd1;
    localparam logic [1:0] FIT_WORST = 2'd2;

    localparam logic [0:0] CFG_FIT_POLICY   = 1'b0;
    localparam logic [0:0] CFG_LINES_IN_USE = 1'b1;

endpackage

[hdl/contiguous_line_allocator_unit.sv]
// Line allocator over a ring of LINES cells, each cell one line (used bit and owner).
// Pulse start while busy is low; one result appears on o_valid for a single cycle
// and cannot be held off. Release and clear rotate the ring once through the head
// cell, one line per cycle; allocate rotates it once to find the run and, when one
// fits, once more to write it; an unused operation code does not rotate the ring.
module contiguous_line_allocator_unit import clau_pkg::*; #(
    parameter int LINES      = 128,
    parameter int OWNER_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_operation,
    input  logic [15:0] i_owner_id,
    input  logic [7:0]  i_run_length,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_idx,
    input  logic [7:0]  i_cfg_data,
    output logic        o_valid,
    output logic        o_granted,
    output logic [6:0]  o_start_line,
    output logic [7:0]  o_lines_released
);

    localparam int CW = $clog2(LINES + 1);
    localparam int IW = $clog2(LINES);
    localparam int LW = (CW > 8) ? CW : 8;
    localparam logic [LW-1:0] LINES_W = LW'(LINES);

    t_state r_state, n_state;

    logic [1:0]            r_fit_policy;
    logic [7:0]            r_lines_in_use;
    logic [LW-1:0]         r_idx, n_idx;
    logic [LW-1:0]         r_run_len, n_run_len;
    logic [IW-1:0]         r_run_start, n_run_start;
    logic                  r_have, n_have;
    logic [IW-1:0]         r_pick_start, n_pick_start;
    logic [LW-1:0]         r_pick_len, n_pick_len;
    logic [LW-1:0]         r_freed, n_freed;
    logic                  r_granted, n_granted;
    logic [1:0]            r_op;
    logic [OWNER_BITS-1:0] r_owner;
    logic [7:0]            r_len;

    logic [LINES-1:0]      cell_used;
    logic [OWNER_BITS-1:0] cell_owner [LINES];
    logic                  tail_used;
    logic [OWNER_BITS-1:0] tail_owner;
    logic                  shift;

    logic [LW-1:0] n_lines;
    logic [LW-1:0] len_w;
    logic [LW-1:0] pick_w;
    logic          in_range;
    logic          is_free;
    logic          accept;
    logic [31:0]   owner_ext;
    logic [31:0]   start_ext;
    logic [31:0]   freed_ext;

    assign accept    = start && !busy;
    assign n_lines   = (LW'(r_lines_in_use) > LINES_W) ? LINES_W : LW'(r_lines_in_use);
    assign len_w     = LW'(r_len);
    assign pick_w    = LW'(r_pick_start);
    assign in_range  = r_idx < n_lines;
    assign is_free   = in_range && !cell_used[0];
    assign owner_ext = {16'd0, i_owner_id};

    // ring of cells; the head's value, after any change, goes to the tail
    genvar k;
    generate
        for (k = 0; k < LINES; k++) begin : g_cell
            logic                  nb_used;
            logic [OWNER_BITS-1:0] nb_owner;
            if (k == LINES - 1) begin : g_tail
                assign nb_used  = tail_used;
                assign nb_owner = tail_owner;
            end else begin : g_mid
                assign nb_used  = cell_used[k+1];
                assign nb_owner = cell_owner[k+1];
            end
            clau_cell #(.OWNER_BITS(OWNER_BITS)) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (shift),
                .i_used  (nb_used),
                .i_owner (nb_owner),
                .o_used  (cell_used[k]),
                .o_owner (cell_owner[k])
            );
        end
    endgenerate

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (t_op'(i_operation))
                        OP_ALLOC:   n_state = S_SCAN;
                        OP_RELEASE: n_state = S_FREE;
                        OP_CLEAR:   n_state = S_FREE;
                        default:    n_state = S_DONE;
                    endcase
                end
            end
            S_SCAN: begin
                if (r_idx == LINES_W) begin
                    n_state = n_have ? S_WRITE : S_DONE;
                end
            end
            S_WRITE: begin
                if (r_idx == LINES_W - 1'b1) n_state = S_DONE;
            end
            S_FREE: begin
                if (r_idx == LINES_W - 1'b1) n_state = S_DONE;
            end
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb begin
        shift        = 1'b0;
        tail_used    = cell_used[0];
        tail_owner   = cell_owner[0];
        n_idx        = r_idx;
        n_run_len    = r_run_len;
        n_run_start  = r_run_start;
        n_have       = r_have;
        n_pick_start = r_pick_start;
        n_pick_len   = r_pick_len;
        n_freed      = r_freed;
        n_granted    = r_granted;
        case (r_state)
            S_IDLE: begin
                n_idx     = '0;
                n_run_len = '0;
                n_have    = 1'b0;
                n_freed   = '0;
                n_granted = 1'b0;
                if (accept && (i_operation == OP_RELEASE || i_operation == OP_CLEAR)) begin
                    n_granted = 1'b1;
                end
            end
            S_SCAN: begin
                shift = r_idx < LINES_W;
                n_idx = r_idx + 1'b1;
                if (is_free) begin
                    n_run_len = r_run_len + 1'b1;
                    if (r_run_len == '0) n_run_start = r_idx[IW-1:0];
                    if (r_fit_policy == FIT_FIRST && !r_have
                        && n_run_len == len_w) begin
                        n_have       = 1'b1;
                        n_pick_start = (r_run_len == '0) ? r_idx[IW-1:0] : r_run_start;
                    end
                end else begin
                    // a free run ends here
                    if (r_run_len >= len_w && r_len != 8'd0) begin
                        if (r_fit_policy == FIT_BEST) begin
                            if (!r_have || r_run_len < r_pick_len) begin
                                n_have       = 1'b1;
                                n_pick_start = r_run_start;
                                n_pick_len   = r_run_len;
                            end
                        end else if (r_fit_policy != FIT_FIRST) begin
                            if (!r_have || r_run_len > r_pick_len) begin
                                n_have       = 1'b1;
                                n_pick_start = r_run_start;
                                n_pick_len   = r_run_len;
                            end
                        end
                    end
                    n_run_len = '0;
                end
                // the run ending at the last line is judged in this same cycle
                if (r_idx == LINES_W) begin
                    n_idx     = '0;
                    n_granted = n_have;
                end
            end
            S_WRITE: begin
                shift = 1'b1;
                n_idx = r_idx + 1'b1;
                if (r_idx >= pick_w && (r_idx - pick_w) < len_w) begin
                    tail_used  = 1'b1;
                    tail_owner = r_owner;
                end
            end
            S_FREE: begin
                shift = 1'b1;
                n_idx = r_idx + 1'b1;
                if (in_range && cell_used[0]
                    && (r_op == OP_CLEAR || cell_owner[0] == r_owner)) begin
                    tail_used = 1'b0;
                    n_freed   = r_freed + 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_fit_policy   <= FIT_FIRST;
            r_lines_in_use <= 8'd128;
            r_idx          <= '0;
            r_have         <= 1'b0;
            r_granted      <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_idx     <= n_idx;
            r_have    <= n_have;
            r_granted <= n_granted;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_FIT_POLICY:   r_fit_policy   <= i_cfg_data[1:0];
                    CFG_LINES_IN_USE: r_lines_in_use <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_run_len    <= n_run_len;
        r_run_start  <= n_run_start;
        r_pick_start <= n_pick_start;
        r_pick_len   <= n_pick_len;
        r_freed      <= n_freed;
        if (accept) begin
            r_op    <= i_operation;
            r_owner <= owner_ext[OWNER_BITS-1:0];
            r_len   <= i_run_length;
        end
    end

    assign start_ext = 32'(r_pick_start);
    assign freed_ext = 32'(r_freed);

    assign busy             = r_state != S_IDLE;
    assign o_valid          = r_state == S_DONE;
    assign o_granted        = o_valid && r_granted;
    assign o_start_line     = (o_granted && r_op == OP_ALLOC) ? start_ext[6:0] : 7'd0;
    assign o_lines_released = (o_valid && r_op != OP_ALLOC && r_op != OP_NONE)
                              ? freed_ext[7:0] : 8'd0;

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !busy)
        else $error("result not followed by idle");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy)
        else $error("accepted item did not start work");

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= LINES_W)
        else $error("line index beyond ring");

    a_write_has_pick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WRITE) |-> r_have)
        else $error("writing without a chosen run");

endmodule

[hdl/clau_cell.sv]
module clau_cell import clau_pkg::*; #(
    parameter int OWNER_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_shift,
    input  logic                  i_used,
    input  logic [OWNER_BITS-1:0] i_owner,
    output logic                  o_used,
    output logic [OWNER_BITS-1:0] o_owner
);

    logic                  r_used;
    logic [OWNER_BITS-1:0] r_owner;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= 1'b0;
        end else if (i_shift) begin
            r_used <= i_used;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_owner <= i_owner;
        end
    end

    assign o_used  = r_used;
    assign o_owner = r_owner;

endmodule
